// ===== hw/rtl/button_press_hold_classifier_unit_defines.svh =====
// assertion macros for the button press and hold classifier
`ifndef BUTTON_PRESS_HOLD_CLASSIFIER_UNIT_DEFINES_SVH
`define BUTTON_PRESS_HOLD_CLASSIFIER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BPHC_ASSERT_IMPLY(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("bphc implication check failed");

// next-cycle implication, checked out of reset
`define BPHC_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("bphc next-cycle check failed");

`endif

// ===== hw/rtl/bphc_pkg.sv =====
// types, constants and helpers for the button press and hold classifier
package bphc_pkg;

    localparam int TIME_WIDTH_DEFAULT = 48;
    localparam int REG_WIDTH          = 24;
    localparam int CFG_INDEX_WIDTH    = 2;
    localparam int CODE_WIDTH         = 3;

    localparam logic [REG_WIDTH-1:0] HOLD_RESET     = 24'd5000000;
    localparam logic [REG_WIDTH-1:0] DEBOUNCE_RESET = 24'd2000000;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLD_DURATION  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE_DELAY = 2'd1;

    localparam logic [CODE_WIDTH-1:0] CODE_NO_PRESS = 3'd0;
    localparam logic [CODE_WIDTH-1:0] CODE_PRESS    = 3'd1;
    localparam logic [CODE_WIDTH-1:0] CODE_DEBOUNCE = 3'd2;
    localparam logic [CODE_WIDTH-1:0] CODE_HOLD     = 3'd3;
    localparam logic [CODE_WIDTH-1:0] CODE_HOLDING  = 3'd4;
    localparam logic [CODE_WIDTH-1:0] CODE_RELEASE  = 3'd5;

    typedef enum logic [5:0] {
        ST_NO_PRESS = 6'b000001,
        ST_PRESS    = 6'b000010,
        ST_DEBOUNCE = 6'b000100,
        ST_HOLD     = 6'b001000,
        ST_HOLDING  = 6'b010000,
        ST_RELEASE  = 6'b100000
    } state_t;

    function automatic logic [CODE_WIDTH-1:0] state_code(input state_t st);
        logic [CODE_WIDTH-1:0] code;
        case (st)
            ST_NO_PRESS: code = CODE_NO_PRESS;
            ST_PRESS:    code = CODE_PRESS;
            ST_DEBOUNCE: code = CODE_DEBOUNCE;
            ST_HOLD:     code = CODE_HOLD;
            ST_HOLDING:  code = CODE_HOLDING;
            ST_RELEASE:  code = CODE_RELEASE;
            default:     code = CODE_NO_PRESS;
        endcase
        return code;
    endfunction

endpackage

// ===== hw/rtl/button_press_hold_classifier_unit.sv =====
// top level of the button press and hold classifier
// usage:
//   input channel (in_valid/in_ready) carries one pin sample: pin_level, low means
//   pressed, and time_us, the sample time in microseconds
//   output channel (out_valid/out_ready) returns one press_class code per sample:
//   0 no press, 1 press, 2 debounce, 3 hold, 4 holding, 5 release
//   config channel (cfg_valid/cfg_ready) writes hold_duration (index 0) or
//   debounce_delay (index 1); other indexes are dropped; always ready
// timing:
//   a sample is registered on transfer into the input register and classified from
//   there into the result register, which raises out_valid
//   one sample per cycle sustained while out_ready is high; the classify step reads the mode and the
//   press and release times it wrote for the sample before
// reset:
//   mode returns to no press, press and release times to zero, registers to
//   5000000 and 2000000 us; both stages empty
// stall:
//   a held result keeps the input register full; one more sample is taken into it,
//   then in_ready drops until out_ready returns
module button_press_hold_classifier_unit #(
    parameter int TIME_WIDTH = bphc_pkg::TIME_WIDTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 pin_level,
    input  logic [TIME_WIDTH-1:0]                time_us,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [bphc_pkg::CODE_WIDTH-1:0]      press_class,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bphc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [bphc_pkg::REG_WIDTH-1:0]       cfg_data
);

    `include "button_press_hold_classifier_unit_defines.svh"

    logic                               s1_valid_reg;
    logic                               s1_pin_reg;
    logic [TIME_WIDTH-1:0]              s1_time_reg;
    logic                               out_valid_reg;
    logic [bphc_pkg::CODE_WIDTH-1:0]    out_code_reg;
    bphc_pkg::state_t                   state_reg;
    bphc_pkg::state_t                   state_next;
    logic [TIME_WIDTH-1:0]              press_time_reg;
    logic [TIME_WIDTH-1:0]              press_time_next;
    logic [TIME_WIDTH-1:0]              release_time_reg;
    logic [TIME_WIDTH-1:0]              release_time_next;
    logic [bphc_pkg::REG_WIDTH-1:0]     hold_duration_reg;
    logic [bphc_pkg::REG_WIDTH-1:0]     debounce_delay_reg;

    logic                               advance;
    logic                               fire;
    logic                               in_xfer;
    logic [TIME_WIDTH-1:0]              elapsed;
    logic                               later;
    logic                               hold_hit;
    logic                               debounce_hit;

    assign advance   = !out_valid_reg || out_ready;
    assign fire      = s1_valid_reg && advance;
    assign in_ready  = !s1_valid_reg || advance;
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign out_valid   = out_valid_reg;
    assign press_class = out_code_reg;

    assign elapsed      = s1_time_reg - press_time_reg;
    assign later        = press_time_reg > release_time_reg;
    assign hold_hit     = (elapsed >= TIME_WIDTH'(hold_duration_reg)) && later;
    assign debounce_hit = (elapsed <= TIME_WIDTH'(debounce_delay_reg)) || later;

    // classification of the sample in the input register
    always_comb
    begin
        state_next        = state_reg;
        press_time_next   = press_time_reg;
        release_time_next = release_time_reg;
        if (!s1_pin_reg)
        begin
            if (hold_hit)
            begin
                if (state_reg == bphc_pkg::ST_HOLD || state_reg == bphc_pkg::ST_HOLDING)
                begin
                    state_next = bphc_pkg::ST_HOLDING;
                end
                else
                begin
                    state_next = bphc_pkg::ST_HOLD;
                end
            end
            else if (debounce_hit)
            begin
                state_next = bphc_pkg::ST_DEBOUNCE;
            end
            else
            begin
                state_next      = bphc_pkg::ST_PRESS;
                press_time_next = s1_time_reg;
            end
        end
        else
        begin
            if (state_reg == bphc_pkg::ST_RELEASE || state_reg == bphc_pkg::ST_NO_PRESS)
            begin
                state_next = bphc_pkg::ST_NO_PRESS;
            end
            else
            begin
                state_next        = bphc_pkg::ST_RELEASE;
                release_time_next = s1_time_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            state_reg        <= bphc_pkg::ST_NO_PRESS;
            press_time_reg   <= '0;
            release_time_reg <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg    <= 1'b1;
                state_reg        <= state_next;
                press_time_reg   <= press_time_next;
                release_time_reg <= release_time_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_pin_reg  <= pin_level;
            s1_time_reg <= time_us;
        end
        if (fire)
        begin
            out_code_reg <= bphc_pkg::state_code(state_next);
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_duration_reg  <= bphc_pkg::HOLD_RESET;
            debounce_delay_reg <= bphc_pkg::DEBOUNCE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bphc_pkg::REG_HOLD_DURATION:  hold_duration_reg  <= cfg_data;
                bphc_pkg::REG_DEBOUNCE_DELAY: debounce_delay_reg <= cfg_data;
                default:                      ;
            endcase
        end
    end

    `BPHC_ASSERT_IMPLY(a_state_onehot, 1'b1, $onehot(state_reg))
    `BPHC_ASSERT_NEXT(a_fire_fills_output, fire, out_valid_reg)
    `BPHC_ASSERT_IMPLY(a_hold_needs_later_press,
        fire && (state_next == bphc_pkg::ST_HOLD || state_next == bphc_pkg::ST_HOLDING),
        press_time_reg > release_time_reg)
    `BPHC_ASSERT_NEXT(a_release_records_time,
        fire && state_next == bphc_pkg::ST_RELEASE,
        release_time_reg == $past(s1_time_reg))

endmodule

// ===== test/tb_top.sv =====
// testbench for the button press and hold classifier: predicts every classification and checks it
`timescale 1ns / 1ps

module tb_top;

    localparam int TW = bphc_pkg::TIME_WIDTH_DEFAULT;
    localparam logic [bphc_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [bphc_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED_3 = 2'd3;
    localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};

    class press_class_board;
        logic [bphc_pkg::REG_WIDTH-1:0]  hold;
        logic [bphc_pkg::REG_WIDTH-1:0]  debounce;
        logic [bphc_pkg::CODE_WIDTH-1:0] mode;
        logic [TW-1:0]                   press_at;
        logic [TW-1:0]                   release_at;
        logic [bphc_pkg::CODE_WIDTH-1:0] expected_states[$];
        int                              mismatches;

        function new();
            hold       = bphc_pkg::HOLD_RESET;
            debounce   = bphc_pkg::DEBOUNCE_RESET;
            mode       = bphc_pkg::CODE_NO_PRESS;
            press_at   = '0;
            release_at = '0;
            mismatches = 0;
        endfunction

        function void write_register(logic [bphc_pkg::CFG_INDEX_WIDTH-1:0] index,
                                     logic [bphc_pkg::REG_WIDTH-1:0] data);
            if (index == bphc_pkg::REG_HOLD_DURATION)
                hold = data;
            else if (index == bphc_pkg::REG_DEBOUNCE_DELAY)
                debounce = data;
        endfunction

        function void classify_sample(logic pin, logic [TW-1:0] now);
            logic [TW-1:0] elapsed;
            bit            later;
            elapsed = now - press_at;
            later   = press_at > release_at;
            if (!pin)
            begin
                if (elapsed >= TW'(hold) && later)
                    mode = (mode == bphc_pkg::CODE_HOLD || mode == bphc_pkg::CODE_HOLDING)
                           ? bphc_pkg::CODE_HOLDING : bphc_pkg::CODE_HOLD;
                else if (elapsed <= TW'(debounce) || later)
                    mode = bphc_pkg::CODE_DEBOUNCE;
                else
                begin
                    press_at = now;
                    mode     = bphc_pkg::CODE_PRESS;
                end
            end
            else if (mode != bphc_pkg::CODE_RELEASE && mode != bphc_pkg::CODE_NO_PRESS)
            begin
                release_at = now;
                mode       = bphc_pkg::CODE_RELEASE;
            end
            else
                mode = bphc_pkg::CODE_NO_PRESS;
            expected_states.push_back(mode);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_state(logic [bphc_pkg::CODE_WIDTH-1:0] got);
            logic [bphc_pkg::CODE_WIDTH-1:0] want;
            if (expected_states.size() == 0)
                report($sformatf("press_class %0d with no sample pending", got));
            else
            begin
                want = expected_states.pop_front();
                if (got !== want)
                    report($sformatf("press_class %0d, expected %0d", got, want));
            end
        endtask
    endclass

    logic                                 clk;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_ready;
    logic                                 pin_level;
    logic [TW-1:0]                        time_us;
    logic                                 out_valid;
    logic                                 out_ready;
    logic [bphc_pkg::CODE_WIDTH-1:0]      press_class;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [bphc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [bphc_pkg::REG_WIDTH-1:0]       cfg_data;

    press_class_board board = new();
    bit               quiet;
    logic [TW-1:0]    clock_now;
    logic             pin_held;
    int               run_left;

    button_press_hold_classifier_unit #(
        .TIME_WIDTH(TW)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .pin_level(pin_level),
        .time_us(time_us),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .press_class(press_class),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    task automatic send_sample(logic pin, logic [TW-1:0] now);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        pin_level <= pin;
        time_us   <= now;
        do @(posedge clk); while (!in_ready);
        board.classify_sample(pin, now);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.expected_states.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_register(logic [bphc_pkg::CFG_INDEX_WIDTH-1:0] index,
                                  logic [bphc_pkg::REG_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        board.write_register(index, data);
        @(negedge clk);
    endtask

    function automatic logic [TW-1:0] random_time();
        return TW'({$urandom, $urandom});
    endfunction

    function automatic logic [TW-1:0] next_time(logic [TW-1:0] last);
        int unsigned span;
        int          r;
        span = 32'((board.hold > board.debounce) ? board.hold : board.debounce);
        r    = $urandom_range(0, 99);
        if (r < 50)
            return last + $urandom_range(0, span / 4 + 1);
        else if (r < 75)
            return last + $urandom_range(0, span + 1);
        else if (r < 88)
            // land on or next to the debounce or hold boundary
            return board.press_at + (r[0] ? board.hold : board.debounce)
                   + $urandom_range(0, 2) - 1;
        else if (r < 94)
            return last;
        else
            return random_time();
    endfunction

    task automatic run_random(int count);
        logic pin;
        for (int k = 0; k < count; k++)
        begin
            if (k % 64 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 59) == 0)
                drain();
            if (run_left == 0)
            begin
                pin_held = ~pin_held;
                run_left = pin_held ? $urandom_range(1, 4) : $urandom_range(1, 12);
            end
            run_left--;
            pin       = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : pin_held;
            clock_now = next_time(clock_now);
            send_sample(pin, clock_now);
        end
    endtask

    task automatic run_phase(logic [bphc_pkg::REG_WIDTH-1:0] hold,
                             logic [bphc_pkg::REG_WIDTH-1:0] deb, int count);
        drain();
        write_register(bphc_pkg::REG_HOLD_DURATION, hold);
        write_register(bphc_pkg::REG_DEBOUNCE_DELAY, deb);
        cfg_valid <= 1'b0;
        clock_now = random_time();
        run_random(count);
    endtask

    task automatic run_receiver();
        int stall;
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 15);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            board.check_state(press_class);
            @(negedge clk);
        end
    endtask

    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        run_receiver();
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        pin_level = 1'b1;
        time_us   = '0;
        cfg_valid = 1'b0;
        cfg_index = bphc_pkg::REG_HOLD_DURATION;
        cfg_data  = '0;
        quiet     = 1'b0;
        pin_held  = 1'b1;
        run_left  = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset registers: release, debounce, press, hold and holding
        send_sample(1'b1, 48'd0);
        send_sample(1'b0, 48'd1000);
        send_sample(1'b1, 48'd2000);
        send_sample(1'b1, 48'd2500);
        send_sample(1'b0, 48'd3_000_000);
        send_sample(1'b0, 48'd3_500_000);
        send_sample(1'b0, 48'd8_000_000);
        send_sample(1'b0, 48'd9_000_000);
        send_sample(1'b1, 48'd9_100_000);
        send_sample(1'b1, 48'd9_200_000);
        send_sample(1'b0, 48'd11_100_001);
        send_sample(1'b0, 48'd13_100_001);
        // time running backward
        send_sample(1'b0, 48'd12_000_000);
        send_sample(1'b1, 48'd12_000_000);
        // elapsed time across the wrap of the timer
        send_sample(1'b0, TIME_MAX);
        send_sample(1'b0, 48'd4_999_998);
        send_sample(1'b0, 48'd4_999_999);
        send_sample(1'b0, 48'd6_000_000);
        // press and release at the same time
        send_sample(1'b1, TIME_MAX);
        send_sample(1'b0, 48'd7_000_000);
        send_sample(1'b1, 48'd7_000_000);
        send_sample(1'b0, 48'd8_000_000);
        send_sample(1'b1, 48'h5555_5555_5555);
        send_sample(1'b0, 48'hAAAA_AAAA_AAAA);
        send_sample(1'b1, 48'hAAAA_AAAA_AAAB);

        clock_now = random_time();
        run_random(150);

        // writes outside the register list are dropped
        drain();
        write_register(REG_UNUSED_2, 24'($urandom));
        write_register(REG_UNUSED_3, 24'($urandom));
        cfg_valid <= 1'b0;
        @(negedge clk);
        run_random(40);

        run_phase(24'd1000, 24'd200, 250);
        run_phase(24'd0, 24'd0, 150);
        run_phase(24'hFFFFFF, 24'hFFFFFF, 150);
        run_phase(24'd0, 24'hFFFFFF, 120);
        run_phase(24'hFFFFFF, 24'd0, 120);
        run_phase(24'd300, 24'd1000, 200);
        run_phase(24'($urandom_range(0, 5000)), 24'($urandom_range(0, 5000)), 120);
        run_phase(24'($urandom), 24'($urandom), 100);

        drain();
        repeat (16) @(posedge clk);
        if (board.expected_states.size() != 0)
            board.report($sformatf("%0d results never arrived", board.expected_states.size()));
        if (board.mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
